// File: hw/rtl/orientation_defect_classifier_defines.svh
// Assertion macros for the orientation defect classifier.
`ifndef ORIENTATION_DEFECT_CLASSIFIER_DEFINES_SVH
`define ORIENTATION_DEFECT_CLASSIFIER_DEFINES_SVH
`ifndef ASSERT_OFF
`define ODC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define ODC_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ODC_ASSERT(label, prop)
`define ODC_ASSERT_RST(label, prop)
`endif
`endif

// File: hw/rtl/odc_pkg.sv
// Shared types, constants and helper functions for the orientation defect classifier.
package odc_pkg;
  localparam int CoordBits  = 8;
  localparam int OrientBits = 16;
  localparam int LabelBits  = 16;
  localparam int CountBits  = 17;
  localparam int AddrBits   = 2 * CoordBits;
  localparam int SumBits    = OrientBits + 4;
  localparam int RingCells  = 24;
  localparam int StepBits   = 5;

  typedef logic [1:0] action_t;
  localparam action_t ActWrite    = 2'd0;
  localparam action_t ActClassify = 2'd1;
  localparam action_t ActClear    = 2'd2;

  typedef logic [1:0] class_t;
  localparam class_t ClsNone     = 2'd0;
  localparam class_t ClsTriple   = 2'd1;
  localparam class_t ClsBoundary = 2'd2;

  typedef struct packed {
    logic write_pixel;
    logic load_item;
    logic clear_counts;
    logic orient_read;
    logic orient_acc;
    logic label_read;
    logic label_acc;
    logic finish;
    logic [StepBits-1:0] step;
  } odc_cmd_t;

  typedef struct packed {
    logic defect;
  } odc_stat_t;

  // Offsets of the eight-neighbour loop, step 8 closes back to step 0.
  function automatic logic signed [2:0] loop_dr(input logic [3:0] k);
    case (k[2:0])
      3'd0: loop_dr = -3'sd1;
      3'd1: loop_dr = 3'sd0;
      3'd2: loop_dr = 3'sd1;
      3'd3: loop_dr = 3'sd1;
      3'd4: loop_dr = 3'sd1;
      3'd5: loop_dr = 3'sd0;
      3'd6: loop_dr = -3'sd1;
      default: loop_dr = -3'sd1;
    endcase
  endfunction

  function automatic logic signed [2:0] loop_dc(input logic [3:0] k);
    case (k[2:0])
      3'd0: loop_dc = -3'sd1;
      3'd1: loop_dc = -3'sd1;
      3'd2: loop_dc = -3'sd1;
      3'd3: loop_dc = 3'sd0;
      3'd4: loop_dc = 3'sd1;
      3'd5: loop_dc = 3'sd1;
      3'd6: loop_dc = 3'sd1;
      default: loop_dc = 3'sd0;
    endcase
  endfunction

  // Ring cells at distance three in row-major order.
  function automatic logic [5:0] ring_off(input logic [StepBits-1:0] j);
    logic [2:0] r;
    logic [2:0] c;
    r = 3'd0;
    c = 3'd0;
    if (j < 5'd7) begin
      r = 3'd0;
      c = j[2:0];
    end else if (j < 5'd17) begin
      r = 3'(((j - 5'd7) >> 1) + 5'd1);
      c = (j[0] == 1'b1) ? 3'd0 : 3'd6;
    end else begin
      r = 3'd6;
      c = 3'(j - 5'd17);
    end
    ring_off = {r, c};
  endfunction
endpackage

// File: hw/rtl/orientation_defect_classifier.sv
// Top level of the orientation defect classifier.
// Write and clear transactions do not raise busy; the block stays ready.
// A classify walks SOrient, SOrientLast, then SLabel, SLabelLast only on a defect, then SDone.
// The rate is set by the single read port of each frame memory, one entry a cycle.
// Synchronous reset clears the counts and the controller; frame memories are not cleared.
// Done flags each result for one cycle; the receiver cannot stall.
module orientation_defect_classifier (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     action,
  input  logic [odc_pkg::CoordBits-1:0]  row,
  input  logic [odc_pkg::CoordBits-1:0]  col,
  input  logic [odc_pkg::OrientBits-1:0] orientation,
  input  logic [odc_pkg::LabelBits-1:0]  grain_label,
  output logic                           done,
  output logic signed [3:0]              winding,
  output logic [1:0]                     defect_class,
  output logic [odc_pkg::CountBits-1:0]  count_negative,
  output logic [odc_pkg::CountBits-1:0]  count_positive,
  output logic [odc_pkg::CountBits-1:0]  count_zero,
  output logic [odc_pkg::CountBits-1:0]  count_triple,
  output logic [odc_pkg::CountBits-1:0]  count_boundary
);
  import odc_pkg::*;

  odc_cmd_t  cmd;
  odc_stat_t stat;

  odc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .action(action), .stat(stat),
    .busy(busy), .cmd(cmd)
  );

  odc_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .row(row), .col(col),
    .orientation(orientation), .grain_label(grain_label), .stat(stat), .done(done),
    .winding(winding), .defect_class(defect_class),
    .count_negative(count_negative), .count_positive(count_positive),
    .count_zero(count_zero), .count_triple(count_triple),
    .count_boundary(count_boundary)
  );
endmodule

// File: hw/rtl/odc_ctrl.sv
// Controller state machine sequencing frame reads for each classify transaction.
module odc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  odc_pkg::action_t   action,
  input  odc_pkg::odc_stat_t stat,
  output logic               busy,
  output odc_pkg::odc_cmd_t  cmd
);
  import odc_pkg::*;
  `include "orientation_defect_classifier_defines.svh"

  typedef enum logic [2:0] {SIdle, SOrient, SOrientLast, SLabel, SLabelLast, SDone} state_t;

  state_t state;
  logic [StepBits-1:0] step;
  logic accept;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle;
      step  <= '0;
      busy  <= 1'b0;
    end else begin
      case (state)
        SIdle: begin
          if (accept && action == ActClassify) begin
            state <= SOrient;
            step  <= '0;
            busy  <= 1'b1;
          end
        end
        SOrient: begin
          step <= step + 5'd1;
          if (step == 5'd8) state <= SOrientLast;
        end
        SOrientLast: begin
          if (stat.defect) begin
            state <= SLabel;
            step  <= '0;
          end else begin
            state <= SDone;
          end
        end
        SLabel: begin
          step <= step + 5'd1;
          if (step == 5'(RingCells - 1)) state <= SLabelLast;
        end
        SLabelLast: state <= SDone;
        SDone: begin
          state <= SIdle;
          busy  <= 1'b0;
        end
        default: begin
          state <= SIdle;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd              = '0;
    cmd.step         = step;
    cmd.write_pixel  = accept && action == ActWrite;
    cmd.clear_counts = accept && action == ActClear;
    cmd.load_item    = accept && action == ActClassify;
    cmd.orient_read  = state == SOrient;
    cmd.orient_acc   = (state == SOrient && step != 5'd0) || state == SOrientLast;
    cmd.label_read   = state == SLabel;
    cmd.label_acc    = (state == SLabel && step != 5'd0) || state == SLabelLast;
    cmd.finish       = state == SDone;
  end

  `ODC_ASSERT(a_busy_idle, (busy == (state != SIdle)))
  `ODC_ASSERT(a_finish_clears, (cmd.finish |=> !busy))
  `ODC_ASSERT(a_start_busy, (accept && action == ActClassify |=> busy))
endmodule

// File: hw/rtl/odc_datapath.sv
// Datapath with frame memories, winding accumulator, label tracker and counters.
module odc_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  odc_pkg::odc_cmd_t               cmd,
  input  logic [odc_pkg::CoordBits-1:0]   row,
  input  logic [odc_pkg::CoordBits-1:0]   col,
  input  logic [odc_pkg::OrientBits-1:0]  orientation,
  input  logic [odc_pkg::LabelBits-1:0]   grain_label,
  output odc_pkg::odc_stat_t              stat,
  output logic                            done,
  output logic signed [3:0]               winding,
  output logic [1:0]                      defect_class,
  output logic [odc_pkg::CountBits-1:0]   count_negative,
  output logic [odc_pkg::CountBits-1:0]   count_positive,
  output logic [odc_pkg::CountBits-1:0]   count_zero,
  output logic [odc_pkg::CountBits-1:0]   count_triple,
  output logic [odc_pkg::CountBits-1:0]   count_boundary
);
  import odc_pkg::*;

  logic [OrientBits-1:0] orient_mem [2**AddrBits];
  logic [LabelBits-1:0]  label_mem  [2**AddrBits];

  logic [CoordBits-1:0] item_row;
  logic [CoordBits-1:0] item_col;
  logic [AddrBits-1:0]  orient_addr;
  logic [AddrBits-1:0]  label_addr;
  logic [OrientBits-1:0] orient_q;
  logic [OrientBits-1:0] prev_orient;
  logic [LabelBits-1:0]  label_q;
  logic signed [SumBits-1:0] wsum;
  logic signed [SumBits-1:0] wsum_next;
  logic signed [OrientBits:0] diff;
  logic signed [OrientBits:0] wdiff;
  logic first_orient;
  logic [LabelBits-1:0] seen0;
  logic [LabelBits-1:0] seen1;
  logic [1:0] nseen;
  logic triple;
  logic [5:0] roff;
  logic signed [3:0] wind_now;
  logic signed [3:0] wind_last;
  localparam logic [CountBits-1:0] CountMax = '1;

  assign roff = ring_off(cmd.step);
  assign orient_addr = {CoordBits'(item_row + CoordBits'(loop_dr(cmd.step[3:0]))),
                        CoordBits'(item_col + CoordBits'(loop_dc(cmd.step[3:0])))};
  assign label_addr = {CoordBits'(item_row + CoordBits'(roff[5:3]) - CoordBits'(3)),
                       CoordBits'(item_col + CoordBits'(roff[2:0]) - CoordBits'(3))};

  always_ff @(posedge clk) begin
    if (cmd.write_pixel) begin
      orient_mem[{row, col}] <= orientation;
      label_mem[{row, col}]  <= grain_label;
    end
    if (cmd.orient_read) orient_q <= orient_mem[orient_addr];
    if (cmd.label_read)  label_q  <= label_mem[label_addr];
  end

  always_comb begin
    diff = $signed({1'b0, orient_q}) - $signed({1'b0, prev_orient});
    if (diff >= $signed({2'b01, {(OrientBits-1){1'b0}}}))
      wdiff = diff - $signed({1'b0, {OrientBits{1'b0}}} | (17'sd1 <<< OrientBits));
    else if (diff <= -$signed({2'b01, {(OrientBits-1){1'b0}}}))
      wdiff = diff + (17'sd1 <<< OrientBits);
    else
      wdiff = diff;
    wsum_next = wsum + SumBits'(wdiff);
  end

  assign wind_now = 4'(wsum >>> OrientBits);
  // The last loop step is still being added while the controller makes its decision.
  assign wind_last = 4'(wsum_next >>> OrientBits);
  assign stat.defect = wind_last != 4'sd0;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_row     <= row;
      item_col     <= col;
      wsum         <= '0;
      first_orient <= 1'b1;
      nseen        <= 2'd0;
      triple       <= 1'b0;
    end
    if (cmd.orient_acc) begin
      prev_orient  <= orient_q;
      first_orient <= 1'b0;
      if (!first_orient) wsum <= wsum_next;
    end
    if (cmd.label_acc && !triple && label_q != '0) begin
      if (!(nseen > 2'd0 && label_q == seen0) && !(nseen > 2'd1 && label_q == seen1)) begin
        if (nseen == 2'd2) triple <= 1'b1;
        else if (nseen == 2'd0) begin
          seen0 <= label_q;
          nseen <= 2'd1;
        end else begin
          seen1 <= label_q;
          nseen <= 2'd2;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done           <= 1'b0;
      count_negative <= '0;
      count_positive <= '0;
      count_zero     <= '0;
      count_triple   <= '0;
      count_boundary <= '0;
    end else begin
      done <= cmd.finish;
      if (cmd.clear_counts) begin
        count_negative <= '0;
        count_positive <= '0;
        count_zero     <= '0;
        count_triple   <= '0;
        count_boundary <= '0;
      end else if (cmd.finish) begin
        winding <= wind_now;
        if (wind_now == -4'sd1 && count_negative != CountMax)
          count_negative <= count_negative + 1'b1;
        if (wind_now == 4'sd0 && count_zero != CountMax)
          count_zero <= count_zero + 1'b1;
        if (wind_now == 4'sd1 && count_positive != CountMax)
          count_positive <= count_positive + 1'b1;
        if (wind_now == 4'sd0) begin
          defect_class <= ClsNone;
        end else if (triple) begin
          defect_class <= ClsTriple;
          if (count_triple != CountMax) count_triple <= count_triple + 1'b1;
        end else begin
          defect_class <= ClsBoundary;
          if (count_boundary != CountMax) count_boundary <= count_boundary + 1'b1;
        end
      end
    end
  end
endmodule

// File: tb/orientation_defect_classifier_test.sv
// Self-checking testbench for the orientation defect classifier: queued stimulus and prediction.
module orientation_defect_classifier_test;
  timeunit 1ns;
  timeprecision 1ps;
  import odc_pkg::*;

  typedef struct {
    logic        hold;
    int          idle_pct;
    action_t     act;
    logic [7:0]  r;
    logic [7:0]  c;
    logic [15:0] o;
    logic [15:0] l;
  } txn_t;

  typedef struct {
    logic signed [3:0]   w;
    class_t              cls;
    logic [CountBits-1:0] neg;
    logic [CountBits-1:0] pos;
    logic [CountBits-1:0] zer;
    logic [CountBits-1:0] trp;
    logic [CountBits-1:0] bnd;
  } verdict_t;

  localparam int CycleLimit = 400000;
  localparam logic [CountBits-1:0] CountTop = '1;
  localparam action_t ActSpare = 2'd3;

  logic clk, rst, start, busy, done;
  logic [1:0] action;
  logic [7:0] row, col;
  logic [15:0] orientation, grain_label;
  logic signed [3:0] winding;
  logic [1:0] defect_class;
  logic [CountBits-1:0] count_negative, count_positive, count_zero, count_triple;
  logic [CountBits-1:0] count_boundary;

  orientation_defect_classifier dut (.*);

  txn_t pending[$];
  verdict_t awaited[$];
  logic [15:0] orient_mem [0:65535];
  logic [15:0] label_mem [0:65535];
  logic [CountBits-1:0] n_neg, n_pos, n_zer, n_tri, n_bnd;
  int fails, cycles, idle_pct;
  txn_t cur;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic logic [CountBits-1:0] sat_inc(logic [CountBits-1:0] v);
    return (v == CountTop) ? v : v + 1'b1;
  endfunction

  function automatic logic [15:0] addr(logic [7:0] r, logic [7:0] c);
    return {r, c};
  endfunction

  function automatic int step_diff(logic [15:0] nx, logic [15:0] pv);
    int d;
    d = int'(nx) - int'(pv);
    if (d < 32768 && d > -32768) return d;
    return (d > 0) ? d - 65536 : d + 65536;
  endfunction

  function automatic bit ring_three(logic [7:0] r, logic [7:0] c);
    logic [15:0] seen [$];
    logic [15:0] lab;
    bit dup;
    for (int dr = -3; dr <= 3; dr++)
      for (int dc = -3; dc <= 3; dc++) begin
        if (dr != 3 && dr != -3 && dc != 3 && dc != -3) continue;
        lab = label_mem[addr(r + 8'(dr), c + 8'(dc))];
        if (lab == 0) continue;
        dup = 0;
        foreach (seen[i]) if (seen[i] == lab) dup = 1;
        if (!dup) seen.push_back(lab);
        if (seen.size() >= 3) return 1;
      end
    return 0;
  endfunction

  task automatic apply_txn(txn_t t);
    int dr [8] = '{-1, 0, 1, 1, 1, 0, -1, -1};
    int dc [8] = '{-1, -1, -1, 0, 1, 1, 1, 0};
    int sum, w;
    verdict_t v;
    case (t.act)
      ActWrite: begin
        orient_mem[addr(t.r, t.c)] = t.o;
        label_mem[addr(t.r, t.c)] = t.l;
      end
      ActClear: begin
        n_neg = 0; n_pos = 0; n_zer = 0; n_tri = 0; n_bnd = 0;
      end
      ActClassify: begin
        sum = 0;
        for (int k = 0; k < 8; k++)
          sum += step_diff(orient_mem[addr(t.r + 8'(dr[(k + 1) % 8]), t.c + 8'(dc[(k + 1) % 8]))],
                           orient_mem[addr(t.r + 8'(dr[k]), t.c + 8'(dc[k]))]);
        w = sum / 65536;
        if (w == -1) n_neg = sat_inc(n_neg);
        else if (w == 0) n_zer = sat_inc(n_zer);
        else if (w == 1) n_pos = sat_inc(n_pos);
        v.cls = ClsNone;
        if (w != 0) begin
          if (ring_three(t.r, t.c)) begin
            v.cls = ClsTriple;
            n_tri = sat_inc(n_tri);
          end else begin
            v.cls = ClsBoundary;
            n_bnd = sat_inc(n_bnd);
          end
        end
        v.w = 4'(w);
        v.neg = n_neg; v.pos = n_pos; v.zer = n_zer; v.trp = n_tri; v.bnd = n_bnd;
        awaited.push_back(v);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      start <= 0;
    end else begin
      if (start && !busy) apply_txn(cur);
      if (!(start && busy)) begin
        while (pending.size() > 0 && pending[0].hold && awaited.size() == 0 && !done)
          void'(pending.pop_front());
        if (pending.size() > 0 && !pending[0].hold
            && $urandom_range(99) >= pending[0].idle_pct) begin
          cur = pending.pop_front();
          start <= 1;
          action <= cur.act;
          row <= cur.r;
          col <= cur.c;
          orientation <= cur.o;
          grain_label <= cur.l;
        end else begin
          start <= 0;
        end
      end
    end
  end

  always @(posedge clk) begin
    verdict_t e;
    if (!rst && done) begin
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result winding %0d", $time, winding);
        fails++;
      end else begin
        e = awaited.pop_front();
        if (winding !== e.w) begin
          $display("%0t: winding exp %0d got %0d", $time, e.w, winding); fails++;
        end
        if (defect_class !== e.cls) begin
          $display("%0t: class exp %0d got %0d", $time, e.cls, defect_class); fails++;
        end
        if (count_negative !== e.neg) begin
          $display("%0t: negative exp %0d got %0d", $time, e.neg, count_negative); fails++;
        end
        if (count_positive !== e.pos) begin
          $display("%0t: positive exp %0d got %0d", $time, e.pos, count_positive); fails++;
        end
        if (count_zero !== e.zer) begin
          $display("%0t: zero exp %0d got %0d", $time, e.zer, count_zero); fails++;
        end
        if (count_triple !== e.trp) begin
          $display("%0t: triple exp %0d got %0d", $time, e.trp, count_triple); fails++;
        end
        if (count_boundary !== e.bnd) begin
          $display("%0t: boundary exp %0d got %0d", $time, e.bnd, count_boundary); fails++;
        end
      end
    end
  end

  task automatic push(action_t a, logic [7:0] r, logic [7:0] c, logic [15:0] o, logic [15:0] l);
    txn_t t;
    t.hold = 0; t.idle_pct = idle_pct; t.act = a; t.r = r; t.c = c; t.o = o; t.l = l;
    pending.push_back(t);
  endtask

  task automatic push_hold();
    txn_t t;
    t = '{hold: 1, idle_pct: 0, act: ActWrite, r: 0, c: 0, o: 0, l: 0};
    pending.push_back(t);
  endtask

  function automatic logic [7:0] centre_pick();
    return $urandom_range(1) ? 8'd255 : 8'd0;
  endfunction

  function automatic logic [15:0] pick_orient();
    case ($urandom_range(3))
      0: return 16'(16384 * $urandom_range(3));
      1: return 16'($urandom_range(65535));
      2: return 16'(32768 + $urandom_range(8) - 4);
      default: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  function automatic logic [15:0] pick_label();
    return ($urandom_range(9) == 0) ? 16'($urandom_range(65535)) : 16'($urandom_range(4));
  endfunction

  task automatic push_vortex(logic [7:0] r, logic [7:0] c, int w, logic [15:0] base, bit jitter);
    int dr [8] = '{-1, 0, 1, 1, 1, 0, -1, -1};
    int dc [8] = '{-1, -1, -1, 0, 1, 1, 1, 0};
    for (int k = 0; k < 8; k++)
      push(ActWrite, r + 8'(dr[k]), c + 8'(dc[k]),
           base + 16'(k * w * 8192) + (jitter ? 16'($urandom_range(2000)) : 16'd0),
           pick_label());
  endtask

  initial begin
    int pct [4] = '{0, 45, 0, 29};
    rst = 1; start = 0; action = 0; row = 0; col = 0; orientation = 0; grain_label = 0;
    n_neg = 0; n_pos = 0; n_zer = 0; n_tri = 0; n_bnd = 0;
    fails = 0; cycles = 0; idle_pct = 0;
    // Fill the window that wraps around the frame corner so the four corner centres are safe.
    for (int i = 0; i < 8; i++)
      for (int j = 0; j < 8; j++)
        push(ActWrite, 8'(252 + i), 8'(252 + j), 16'h0000, 16'(((i / 3) + (j / 3)) % 3 + 1));
    push(ActClassify, 8'd255, 8'd255, 0, 0);
    push_vortex(8'd0, 8'd0, 1, 16'hFFFF, 0);
    push(ActClassify, 8'd0, 8'd0, 0, 0);
    push_vortex(8'd255, 8'd0, -1, 16'h0000, 0);
    push(ActClassify, 8'd255, 8'd0, 0, 0);
    push_vortex(8'd0, 8'd255, 4, 16'h0000, 0);
    push(ActClassify, 8'd0, 8'd255, 0, 0);
    push(ActWrite, 8'd3, 8'd3, 16'hFFFF, 16'hFFFF);
    push(ActClassify, 8'd0, 8'd0, 0, 0);
    push(ActSpare, 8'd0, 8'd0, 0, 0);
    push(ActClear, 8'd0, 8'd0, 0, 0);
    push(ActClassify, 8'd0, 8'd255, 0, 0);
    for (int p = 0; p < 4; p++) begin
      push_hold();
      for (int n = 0; n < 150; ) begin
        idle_pct = pct[p];
        case ($urandom_range(19))
          0, 1: begin
            push_vortex(centre_pick(), centre_pick(), int'($urandom_range(8)) - 4,
                        16'($urandom_range(65535)), $urandom_range(1));
            n += 8;
          end
          2: begin push(ActClear, 8'($urandom_range(255)), 8'($urandom_range(255)),
                        16'($urandom_range(65535)), 16'($urandom_range(65535))); n++; end
          3: begin push(ActSpare, 8'($urandom_range(255)), 8'($urandom_range(255)),
                        16'($urandom_range(65535)), 16'($urandom_range(65535))); end
          4: begin push(ActWrite, 8'($urandom_range(255)), 8'($urandom_range(255)),
                        16'($urandom_range(65535)), 16'($urandom_range(65535))); n++; end
          5, 6, 7, 8, 9, 10: begin
            push(ActClassify, centre_pick(), centre_pick(), 16'($urandom_range(65535)),
                 16'($urandom_range(65535)));
            n++;
          end
          default: begin
            push(ActWrite, 8'(252 + $urandom_range(7)), 8'(252 + $urandom_range(7)),
                 pick_orient(), pick_label());
            n++;
          end
        endcase
      end
    end
    repeat (2) @(posedge clk);
    rst <= 0;
    while (pending.size() != 0 || awaited.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (fails == 0 && awaited.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/odc_pkg.sv
hw/rtl/odc_ctrl.sv
hw/rtl/odc_datapath.sv
hw/rtl/orientation_defect_classifier.sv
tb/orientation_defect_classifier_test.sv
